@@ hw/rtl/connection_table_with_aging_assert.svh @@
// Assertion macros for the connection table.
// Used by connection_table_with_aging; needs clk and rst_n in scope.
`ifndef CONNECTION_TABLE_WITH_AGING_ASSERT_SVH
`define CONNECTION_TABLE_WITH_AGING_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CTA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("connection table check failed");

// Next-cycle implication, disabled in reset.
`define CTA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("connection table check failed");

`endif

@@ hw/rtl/cta_pkg.sv @@
// Shared types and constants of the connection table.
// Used by cta_cell, cta_chain and connection_table_with_aging.
package cta_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int OP_W      = 2;
  localparam int CNT_OUT_W = 5;
  localparam int LIMIT_W   = 5;
  localparam int CFG_IDX_W = 4;

  typedef logic [OP_W-1:0] opcode_t;
  localparam opcode_t OP_CONNECT    = 2'd0;
  localparam opcode_t OP_DISCONNECT = 2'd1;
  localparam opcode_t OP_ADVANCE    = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TABLE_LIMIT = 4'd0;
  localparam cfg_idx_t CFG_EXPIRY_AGE  = 4'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 5'd16;
  localparam logic [WORD_W-1:0]  EXPIRY_RST = 32'd1000;

  typedef struct packed {
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctl_t;

  typedef struct packed {
    logic take_nbr;
    logic take_ins;
  } cell_ctl_t;

endpackage

@@ hw/rtl/cta_cell.sv @@
// One table cell: holds an entry, takes its neighbor's or the inserted entry.
// Depends on cta_pkg.
module cta_cell (
  input  logic               clk,
  input  cta_pkg::cell_ctl_t ctl,
  input  cta_pkg::entry_t    nbr,
  input  cta_pkg::entry_t    ins,
  output cta_pkg::entry_t    entry
);
  import cta_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.take_ins) begin
      entry_nxt = ins;
    end else if (ctl.take_nbr) begin
      entry_nxt = nbr;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

@@ hw/rtl/cta_chain.sv @@
// Row of table cells shifting toward the head, with one insertion point.
// Depends on cta_pkg and cta_cell.
module cta_chain #(
  parameter int DEPTH = cta_pkg::DEPTH_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  cta_pkg::chain_ctl_t ctl,
  input  logic [IW-1:0]       load_idx,
  input  cta_pkg::entry_t     ins,
  output cta_pkg::entry_t     head
);
  import cta_pkg::*;

  entry_t cells [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t cctl;
    entry_t    nbr;

    assign cctl.take_ins = ctl.load && (load_idx == IW'(i));
    assign cctl.take_nbr = ctl.shift;

    if (i == DEPTH - 1) begin : g_tail
      assign nbr = ins;
    end else begin : g_body
      assign nbr = cells[i+1];
    end

    cta_cell u_cell (
      .clk   (clk),
      .ctl   (cctl),
      .nbr   (nbr),
      .ins   (ins),
      .entry (cells[i])
    );
  end

  assign head = cells[0];

endmodule

@@ hw/rtl/connection_table_with_aging.sv @@
// Connection table with timeout aging: control, clock and config registers.
// Depends on cta_pkg, cta_chain and connection_table_with_aging_assert.svh.
//
// An item is taken when start is high and busy is low. Its single result
// appears on out_valid for one cycle and cannot be held off. Connect and the
// unused opcode finish at once: the result follows in the cycle after start
// and busy stays low. Disconnect and advance walk the live entries through
// the head of the cell row, one entry per cycle, so busy stays high while
// the n live entries (1 to TABLE_DEPTH) are walked, and the result follows
// in the cycle after the last step, as busy falls; with an empty table they
// finish at once. The table is empty after reset, and no clearing pass is
// needed. cfg_ready is always high.
module connection_table_with_aging #(
  parameter int TABLE_DEPTH = cta_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  cta_pkg::opcode_t               in_opcode,
  input  logic signed [cta_pkg::WORD_W-1:0] in_device_id,
  input  logic [cta_pkg::WORD_W-1:0]     in_tick_amount,
  output logic                           out_valid,
  output logic                           out_accepted,
  output logic [cta_pkg::CNT_OUT_W-1:0]  out_entry_count,
  output logic [cta_pkg::CNT_OUT_W-1:0]  out_expired_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  cta_pkg::cfg_idx_t              cfg_index,
  input  logic [cta_pkg::WORD_W-1:0]     cfg_data
);
  import cta_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          live_r, live_nxt;
  logic [WORD_W-1:0]      clock_r, clock_nxt;
  opcode_t                op_r, op_nxt;
  logic [WORD_W-1:0]      id_r, id_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic [CW-1:0]          w_r, w_nxt;
  logic                   found_r, found_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   acc_r, acc_nxt;
  logic [CNT_OUT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_OUT_W-1:0]   exp_r, exp_nxt;
  logic [LIMIT_W-1:0]     limit_r;
  logic [WORD_W-1:0]      expiry_r;

  chain_ctl_t             chain_ctl;
  logic [IW-1:0]          load_idx;
  entry_t                 ins_entry;
  entry_t                 head;

  logic [WORD_W-1:0]      age;
  logic                   keep;
  logic                   last;
  logic                   room;
  logic [CW-1:0]          tgt;
  logic [CW-1:0]          w_inc;
  logic [CW-1:0]          live_inc;

  cta_chain #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_chain (
    .clk      (clk),
    .ctl      (chain_ctl),
    .load_idx (load_idx),
    .ins      (ins_entry),
    .head     (head)
  );

  assign ins_entry.id    = (state_r == ST_WALK) ? head.id : in_device_id;
  assign ins_entry.stamp = (state_r == ST_WALK) ? head.stamp : clock_r;

  assign age      = clock_r - head.stamp;
  assign keep     = (op_r == OP_DISCONNECT) ? (found_r || (head.id != id_r))
                                            : (age < expiry_r);
  assign last     = (k_r == (live_r - CW'(1)));
  assign tgt      = live_r - CW'(1) - k_r + w_r;
  assign w_inc    = w_r + CW'(keep);
  assign live_inc = live_r + CW'(1);
  assign room     = (LW'(live_r) < LW'(limit_r)) && (LW'(live_r) < LW'(TABLE_DEPTH));

  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    clock_nxt     = clock_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    exp_nxt       = exp_r;
    chain_ctl     = '0;
    load_idx      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = in_opcode;
          id_nxt    = in_device_id;
          k_nxt     = '0;
          w_nxt     = '0;
          found_nxt = 1'b0;
          unique case (in_opcode) inside
            OP_CONNECT: begin
              out_valid_nxt = 1'b1;
              exp_nxt       = '0;
              if (room) begin
                chain_ctl.load = 1'b1;
                load_idx       = live_r[IW-1:0];
                live_nxt       = live_inc;
                acc_nxt        = 1'b1;
                cnt_nxt        = CNT_OUT_W'(live_inc);
              end else begin
                acc_nxt = 1'b0;
                cnt_nxt = CNT_OUT_W'(live_r);
              end
            end
            OP_DISCONNECT, OP_ADVANCE: begin
              if (in_opcode == OP_ADVANCE) begin
                clock_nxt = clock_r + in_tick_amount;
              end
              if (live_r == '0) begin
                out_valid_nxt = 1'b1;
                acc_nxt       = 1'b0;
                cnt_nxt       = '0;
                exp_nxt       = '0;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              acc_nxt       = 1'b0;
              cnt_nxt       = CNT_OUT_W'(live_r);
              exp_nxt       = '0;
            end
          endcase
        end
      end
      ST_WALK: begin
        chain_ctl.shift = 1'b1;
        chain_ctl.load  = keep;
        load_idx        = tgt[IW-1:0];
        k_nxt           = k_r + CW'(1);
        w_nxt           = w_inc;
        found_nxt       = found_r || ((op_r == OP_DISCONNECT) && !keep);
        if (last) begin
          state_nxt     = ST_IDLE;
          live_nxt      = w_inc;
          out_valid_nxt = 1'b1;
          acc_nxt       = (op_r == OP_DISCONNECT) && found_nxt;
          cnt_nxt       = CNT_OUT_W'(w_inc);
          exp_nxt       = (op_r == OP_ADVANCE) ? CNT_OUT_W'(live_r - w_inc) : '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_r      <= '0;
      clock_r     <= '0;
      k_r         <= '0;
      w_r         <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      clock_r     <= clock_nxt;
      k_r         <= k_nxt;
      w_r         <= w_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    id_r  <= id_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    exp_r <= exp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RST;
      expiry_r <= EXPIRY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TABLE_LIMIT: limit_r  <= cfg_data[LIMIT_W-1:0];
        CFG_EXPIRY_AGE:  expiry_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready         = 1'b1;
  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_accepted      = acc_r;
  assign out_entry_count   = cnt_r;
  assign out_expired_count = exp_r;

  `include "connection_table_with_aging_assert.svh"

  `CTA_ASSERT_IMP(a_live_bound, 1'b1, live_r <= CW'(TABLE_DEPTH))
  `CTA_ASSERT_IMP(a_walk_in_range, state_r == ST_WALK, k_r < live_r && w_r <= k_r)
  `CTA_ASSERT_NXT(a_connect_done, start && !busy && in_opcode == OP_CONNECT, out_valid && !busy)
  `CTA_ASSERT_IMP(a_expired_only_advance, out_valid && out_expired_count != '0, op_r == OP_ADVANCE)

endmodule
